/* rtl/bitmap_block_allocator_unit_defines.svh */
// Assertion macros shared by the bitmap block allocator checker.
// Standalone header with no dependencies.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Clocked assertion that is disabled while reset is asserted.
`define BBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bba_pkg.sv */
// Shared types and constants of the bitmap block allocator.
// No dependencies; used by bba_word_scan, the top level and the checker.
package bba_pkg;

    localparam int MAX_BLOCKS  = 4096;
    localparam int WORD_BITS   = 32;
    localparam int WORD_COUNT  = MAX_BLOCKS / WORD_BITS;
    localparam int WORD_AW     = $clog2(WORD_COUNT);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int BLOCK_W     = 12;
    localparam int TOTAL_W     = 13;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(MAX_BLOCKS);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE     = 2'd1;
    localparam logic [1:0] STATUS_ALREADY_FREE = 2'd2;
    localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK
    } t_state;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_idx;
        logic             last;
    } t_scan_res;

endpackage

/* rtl/bba_bitmap_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bba_bitmap_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bba_word_scan.sv */
// Finds the first free block in one bitmap word, below the block limit.
// Depends on bba_pkg.
module bba_word_scan (
    input  logic [bba_pkg::WORD_BITS-1:0] i_word_data,
    input  logic [bba_pkg::WORD_AW-1:0]   i_word_idx,
    input  logic [bba_pkg::TOTAL_W-1:0]   i_limit,
    output bba_pkg::t_scan_res            o_res
);

    logic [bba_pkg::TOTAL_W-1:0] base;
    logic [bba_pkg::TOTAL_W-1:0] remaining;

    always_comb begin
        base      = bba_pkg::TOTAL_W'({i_word_idx, {bba_pkg::BIT_W{1'b0}}});
        remaining = (i_limit > base) ? (i_limit - base) : '0;
        o_res.last = (remaining <= bba_pkg::TOTAL_W'(bba_pkg::WORD_BITS)) ||
                     (i_word_idx == bba_pkg::WORD_AW'(bba_pkg::WORD_COUNT - 1));
        o_res.found   = 1'b0;
        o_res.bit_idx = '0;
        for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--) begin
            if ((bba_pkg::TOTAL_W'(b) < remaining) && !i_word_data[b]) begin
                o_res.found   = 1'b1;
                o_res.bit_idx = bba_pkg::BIT_W'(b);
            end
        end
    end

endmodule

/* rtl/bitmap_block_allocator_unit.sv */
// Bitmap first-fit block allocator, top level.
// Depends on bba_pkg, bba_bitmap_ram and bba_word_scan.
//
// Usage: an input transfer (i_in_valid high, o_in_stall low) carries a
// function (allocate or free) and a block number. Each input transfer yields
// exactly one output transfer (o_out_valid high, i_out_stall low) with a
// status and, for a successful allocate, the granted block number.
// The usage bitmap lives in a 128 x 32 synchronous RAM. A free request reads
// its word and, if the block is in use, writes it back with the bit cleared;
// the next request is taken once the result is in the output register.
// An allocate request reads one bitmap word per cycle from word 0 upward
// until a free bit is found or the block limit is reached, at most 128 words,
// and marks the granted bit used; the next request is likewise taken once
// the result is in the output register.
// After reset the block clears all 128 bitmap words while o_in_stall
// is high; configuration writes are taken at any time.
// The result sits in an output register. While the receiver stalls, the next
// request is accepted and processed, and its write-back waits until the
// output register is free.
module bitmap_block_allocator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bba_pkg::TOTAL_W-1:0]   i_cfg_total_blocks,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [bba_pkg::BLOCK_W-1:0]   i_block_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [bba_pkg::BLOCK_W-1:0]   o_granted_block
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;

    logic [bba_pkg::WORD_AW-1:0]   r_clr_addr;
    logic [bba_pkg::WORD_AW-1:0]   r_word;
    logic [bba_pkg::WORD_AW-1:0]   n_word;
    logic                          r_func;
    logic [bba_pkg::BLOCK_W-1:0]   r_blk;
    logic [bba_pkg::TOTAL_W-1:0]   r_total;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [1:0]                    r_status;
    logic [bba_pkg::BLOCK_W-1:0]   r_grant;

    logic                          in_fire;
    logic                          out_free;
    logic                          done;
    logic                          commit;
    logic [bba_pkg::TOTAL_W-1:0]   limit;
    logic                          ram_we;
    logic [bba_pkg::WORD_AW-1:0]   ram_waddr;
    logic [bba_pkg::WORD_BITS-1:0] ram_wdata;
    logic [bba_pkg::WORD_AW-1:0]   ram_raddr;
    logic [bba_pkg::WORD_BITS-1:0] ram_rdata;
    bba_pkg::t_scan_res            scan;
    logic                          blk_oor;
    logic                          blk_used;
    logic [1:0]                    res_status;
    logic [bba_pkg::BLOCK_W-1:0]   res_grant;
    logic                          res_write;
    logic [bba_pkg::WORD_BITS-1:0] res_word;

    bba_bitmap_ram #(
        .DEPTH (bba_pkg::WORD_COUNT),
        .WIDTH (bba_pkg::WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bba_word_scan u_scan (
        .i_word_data (ram_rdata),
        .i_word_idx  (r_word),
        .i_limit     (limit),
        .o_res       (scan)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != bba_pkg::ST_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign limit       = (r_total > bba_pkg::TOTAL_W'(bba_pkg::MAX_BLOCKS)) ?
                         bba_pkg::TOTAL_W'(bba_pkg::MAX_BLOCKS) : r_total;

    always_comb begin
        blk_oor  = ({1'b0, r_blk} >= limit);
        blk_used = ram_rdata[r_blk[bba_pkg::BIT_W-1:0]];
        res_word  = ram_rdata;
        res_write = 1'b0;
        res_grant = '0;
        if (r_func == bba_pkg::FUNC_FREE) begin
            done = 1'b1;
            if (blk_oor) begin
                res_status = bba_pkg::STATUS_OUT_OF_RANGE;
            end else if (!blk_used) begin
                res_status = bba_pkg::STATUS_ALREADY_FREE;
            end else begin
                res_status = bba_pkg::STATUS_OK;
                res_write  = 1'b1;
                res_word[r_blk[bba_pkg::BIT_W-1:0]] = 1'b0;
            end
        end else begin
            done = scan.found || scan.last;
            if (scan.found) begin
                res_status = bba_pkg::STATUS_OK;
                res_write  = 1'b1;
                res_grant  = {r_word, scan.bit_idx};
                res_word[scan.bit_idx] = 1'b1;
            end else begin
                res_status = bba_pkg::STATUS_NO_SPACE;
            end
        end
        commit = (r_state == bba_pkg::ST_CHECK) && done && out_free;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            bba_pkg::ST_CLEAR: begin
                if (r_clr_addr == bba_pkg::WORD_AW'(bba_pkg::WORD_COUNT - 1)) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = bba_pkg::ST_CHECK;
                end
            end
            bba_pkg::ST_CHECK: begin
                if (commit) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_word;
        ram_wdata = res_word;
        ram_raddr = r_word;
        n_word    = r_word;
        case (r_state)
            bba_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            bba_pkg::ST_IDLE: begin
                if (i_func == bba_pkg::FUNC_FREE) begin
                    ram_raddr = i_block_number[bba_pkg::BLOCK_W-1:bba_pkg::BIT_W];
                end else begin
                    ram_raddr = '0;
                end
                n_word = ram_raddr;
            end
            bba_pkg::ST_CHECK: begin
                if (!done) begin
                    n_word    = r_word + 1'b1;
                    ram_raddr = n_word;
                end
                ram_we = commit && res_write;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
        n_out_valid = commit || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_total     <= bba_pkg::TOTAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == bba_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_total <= i_cfg_total_blocks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (in_fire) begin
            r_func <= i_func;
            r_blk  <= i_block_number;
        end
        if (commit) begin
            r_status <= res_status;
            r_grant  <= res_grant;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_granted_block = r_grant;

endmodule

/* rtl/bba_checker.sv */
// Port-level checker for the bitmap block allocator, bound to the top level.
// Depends on bba_pkg and bitmap_block_allocator_unit_defines.svh.
`include "bitmap_block_allocator_unit_defines.svh"

module bba_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [1:0]                  o_status,
    input logic [bba_pkg::BLOCK_W-1:0] o_granted_block
);

    `BBA_ASSERT_ALWAYS(a_reset_blocks, i_clk, !i_rst_n |=> (o_in_stall && !o_out_valid), "input must stall and output be idle after reset")

    `BBA_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "a second transfer was accepted while a request was in progress")

    `BBA_ASSERT(a_grant_zero, i_clk, i_rst_n, (o_out_valid && (o_status != bba_pkg::STATUS_OK)) |-> (o_granted_block == '0), "granted block must be zero on a failed request")

    `BBA_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status) && $stable(o_granted_block)), "stalled result changed")

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_granted_block (o_granted_block)
);

/* dv/bitmap_block_allocator_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the bitmap block allocator: an internal bitmap predictor
// checks every result transfer across block-count settings, idle and stall patterns.
// Depends on bba_pkg and bitmap_block_allocator_unit.
module bitmap_block_allocator_unit_tb;
    import bba_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic               func;
        logic [BLOCK_W-1:0] blk;
    } t_request;

    typedef struct packed {
        logic [1:0]         status;
        logic [BLOCK_W-1:0] grant;
    } t_reply;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [TOTAL_W-1:0] i_cfg_total_blocks = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_func = FUNC_ALLOC;
    logic [BLOCK_W-1:0] i_block_number = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic [BLOCK_W-1:0] o_granted_block;

    t_request              pending_requests[$];
    t_reply                expected_replies[$];
    logic [MAX_BLOCKS-1:0] used_map = '0;
    logic [TOTAL_W-1:0]    block_count = TOTAL_RESET;
    int                    send_idle_pct = 0;
    int                    stall_pct = 0;
    logic                  hold_go = 1'b0;
    logic                  hold_on = 1'b0;
    int                    error_count = 0;
    int                    cycle_count = 0;
    int                    settings_used = 0;
    int                    status_seen [4] = '{default: 0};

    bitmap_block_allocator_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_total_blocks (i_cfg_total_blocks),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_block_number     (i_block_number),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_granted_block    (o_granted_block)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int block_limit();
        return (block_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count);
    endfunction

    function automatic t_reply grant_or_release(t_request req);
        t_reply r;
        int     lim;
        lim = block_limit();
        r.status = STATUS_NO_SPACE;
        r.grant = '0;
        if (req.func == FUNC_ALLOC) begin
            for (int b = 0; b < lim; b++) begin
                if (!used_map[b]) begin
                    used_map[b] = 1'b1;
                    r.grant = BLOCK_W'(b);
                    r.status = STATUS_OK;
                    break;
                end
            end
        end else if (int'(req.blk) >= lim) begin
            r.status = STATUS_OUT_OF_RANGE;
        end else if (!used_map[req.blk]) begin
            r.status = STATUS_ALREADY_FREE;
        end else begin
            used_map[req.blk] = 1'b0;
            r.status = STATUS_OK;
        end
        return r;
    endfunction

    function automatic int pick_used_block(int lim);
        int start;
        int b;
        if (lim == 0) begin
            return $urandom_range(MAX_BLOCKS - 1);
        end
        start = $urandom_range(lim - 1);
        for (int i = 0; i < lim; i++) begin
            b = (start + i) % lim;
            if (used_map[b]) begin
                return b;
            end
        end
        return start;
    endfunction

    always @(posedge i_clk) begin : driver
        t_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req = pending_requests.pop_front();
                i_in_valid <= 1'b1;
                i_func <= req.func;
                i_block_number <= req.blk;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= hold_on || ($urandom_range(99) < stall_pct);
        end
    end

    initial begin : hold_off
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    always @(posedge i_clk) begin : monitor
        t_request req;
        t_reply   exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: expected no result, got status %0d block %0d",
                             $time, o_status, o_granted_block);
                    error_count++;
                end else begin
                    exp_r = expected_replies.pop_front();
                    status_seen[exp_r.status]++;
                    if (o_status !== exp_r.status) begin
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, exp_r.status, o_status);
                        error_count++;
                    end
                    if (o_granted_block !== exp_r.grant) begin
                        $display("%0t: granted block expected %0d, actual %0d",
                                 $time, exp_r.grant, o_granted_block);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                req.func = i_func;
                req.blk = i_block_number;
                expected_replies.push_back(grant_or_release(req));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                block_count = i_cfg_total_blocks;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_block_count(input logic [TOTAL_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_total_blocks <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic queue_request(input logic func, input int blk);
        t_request req;
        req.func = func;
        req.blk = BLOCK_W'(blk);
        pending_requests.push_back(req);
    endtask

    task automatic drain();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || expected_replies.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_random(input int count, input int alloc_pct);
        int r;
        int lim;
        int used_top;
        int range_top;
        used_top = alloc_pct + (100 - alloc_pct) * 6 / 10;
        range_top = used_top + (100 - alloc_pct) * 2 / 10;
        for (int n = 0; n < count; n++) begin
            @(negedge i_clk);
            while (pending_requests.size() >= 2) @(negedge i_clk);
            r = $urandom_range(99);
            lim = block_limit();
            if (r < alloc_pct) begin
                queue_request(FUNC_ALLOC, $urandom_range(MAX_BLOCKS - 1));
            end else if (r < used_top) begin
                queue_request(FUNC_FREE, pick_used_block(lim));
            end else if (r < range_top && lim > 0) begin
                queue_request(FUNC_FREE, $urandom_range(lim - 1));
            end else begin
                queue_request(FUNC_FREE, $urandom_range(MAX_BLOCKS - 1));
            end
        end
    endtask

    initial begin : stimulus
        int phase_total [6] = '{40, 4096, 100, 33, 1000, 5};
        int phase_idle  [6] = '{0, 88, 0, 32, 0, 32};
        int phase_stall [6] = '{0, 0, 88, 32, 0, 32};
        int phase_items [6] = '{200, 200, 200, 150, 150, 100};
        int phase_alloc [6] = '{55, 70, 55, 50, 55, 50};
        int results;

        while (!i_rst_n) @(negedge i_clk);

        // First-fit order, double free and the top block number at the reset count.
        queue_request(FUNC_ALLOC, 0);
        queue_request(FUNC_ALLOC, MAX_BLOCKS - 1);
        queue_request(FUNC_ALLOC, 0);
        queue_request(FUNC_FREE, 1);
        queue_request(FUNC_FREE, 1);
        queue_request(FUNC_ALLOC, 0);
        queue_request(FUNC_FREE, MAX_BLOCKS - 1);
        queue_request(FUNC_FREE, 0);
        queue_request(FUNC_ALLOC, 0);
        drain();

        // With no blocks, allocate finds nothing and every free is out of range.
        write_block_count('0);
        queue_request(FUNC_ALLOC, 0);
        queue_request(FUNC_FREE, 0);
        drain();

        // A single block; blocks above the count keep their bits.
        write_block_count(TOTAL_W'(1));
        queue_request(FUNC_ALLOC, 0);
        queue_request(FUNC_FREE, 1);
        queue_request(FUNC_FREE, 0);
        queue_request(FUNC_ALLOC, 0);
        queue_request(FUNC_ALLOC, 0);
        drain();

        // A count above the maximum saturates.
        write_block_count({TOTAL_W{1'b1}});
        queue_request(FUNC_ALLOC, 0);
        queue_request(FUNC_FREE, MAX_BLOCKS - 1);
        queue_request(FUNC_FREE, MAX_BLOCKS - 2);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_block_count(TOTAL_W'(phase_total[p]));
            @(negedge i_clk);
            send_idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            if (p == 4) begin
                hold_go = 1'b1;
            end
            run_random(phase_items[p], phase_alloc[p]);
            drain();
        end

        results = status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3];
        $display("Checked %0d results over %0d block-count settings in %0d cycles",
                 results, settings_used, cycle_count);
        $display("Results: %0d ok, %0d no free block, %0d already free, %0d out of range",
                 status_seen[STATUS_OK], status_seen[STATUS_NO_SPACE],
                 status_seen[STATUS_ALREADY_FREE], status_seen[STATUS_OUT_OF_RANGE]);
        if (error_count == 0 && expected_replies.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/bba_pkg.sv
rtl/bba_bitmap_ram.sv
rtl/bba_word_scan.sv
rtl/bitmap_block_allocator_unit.sv
rtl/bba_checker.sv
dv/bitmap_block_allocator_unit_tb.sv
